/* sv/ccbd_pkg.sv */
// Shared constants and types of the CPU bus decoder.
`timescale 1ns / 1ps

package ccbd_pkg;

   // Work RAM geometry
   localparam int RAM_DEPTH = 2048;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam int DATA_W    = 8;

   // Result targets
   localparam logic [2:0] TGT_NONE  = 3'd0;
   localparam logic [2:0] TGT_RAM   = 3'd1;
   localparam logic [2:0] TGT_VIDEO = 3'd2;
   localparam logic [2:0] TGT_AUDIO = 3'd3;
   localparam logic [2:0] TGT_DMA   = 3'd4;
   localparam logic [2:0] TGT_PAD   = 3'd5;
   localparam logic [2:0] TGT_CART  = 3'd6;

   // Bus commands
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Address map
   localparam logic [15:0] MIRROR_MASK   = 16'hE000;
   localparam logic [15:0] RAM_BASE      = 16'h0000;
   localparam logic [15:0] VIDEO_BASE    = 16'h2000;
   localparam logic [15:0] VIDEO_REG_MSK = 16'h0007;
   localparam logic [15:0] PAGE_MASK     = 16'hF000;
   localparam logic [15:0] IO_PAGE       = 16'h4000;
   localparam logic [15:0] AUDIO_LAST    = 16'h4013;
   localparam logic [15:0] DMA_ADDR      = 16'h4014;
   localparam logic [15:0] AUDIO_STATUS  = 16'h4015;
   localparam logic [15:0] PAD_ADDR      = 16'h4016;
   localparam logic [15:0] AUDIO_FRAME   = 16'h4017;
   localparam logic [7:0]  PAD_OPEN_BUS  = 8'h40;

   // Control states
   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

endpackage

/* sv/ccbd_if.sv */
// Valid/ready channel interfaces for bus accesses and decoded results.
`timescale 1ns / 1ps

interface ccbd_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic [7:0]  buttons;
   logic        cart_hit;
   logic [7:0]  cart_read_data;
   logic [7:0]  video_read_data;

   modport source (output valid, command, address, write_data, buttons, cart_hit,
                   cart_read_data, video_read_data, input ready);
   modport sink (input valid, command, address, write_data, buttons, cart_hit,
                 cart_read_data, video_read_data, output ready);
endinterface

interface ccbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [2:0]  target;
   logic [15:0] device_address;
   logic [7:0]  device_data;

   modport source (output valid, read_data, target, device_address, device_data,
                   input ready);
   modport sink (input valid, read_data, target, device_address, device_data,
                 output ready);
endinterface

/* sv/ccbd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ccbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, holds its data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/console_cpu_bus_decoder_core.sv */
// Top level: CPU bus address decoder with work RAM and controller port.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+--------------------------------------------
//  req_ch   | in  | valid/ready  | command, address, write_data, buttons,
//           |     |              | cart_hit, cart_read_data, video_read_data
//  rsp_ch   | out | valid/ready  | read_data, target, device_address,
//           |     |              | device_data
//
// An access is decoded at its transfer, where the work RAM read is also
// registered; the result moves into the output register once that register is
// free or being taken. With rsp_ch ready an access is taken every cycle.
// After reset the work RAM is cleared one entry a cycle, all 2048 entries, with
// req_ch ready low. A stalled result holds one access in flight and blocks
// further transfers; the controller state is updated at the transfer.
`timescale 1ns / 1ps

module console_cpu_bus_decoder_core (
   input  logic       clock,
   input  logic       reset,
   ccbd_req_if.sink   req_ch,
   ccbd_rsp_if.source rsp_ch
);

   import ccbd_pkg::*;

   state_type          state_ff, state_in;
   logic [RAM_AW-1:0]  clr_ff, clr_in;
   logic               pend_ff;
   logic               pad_strobe_ff, pad_strobe_in;
   logic [7:0]         pad_shift_ff, pad_shift_in;

   // Decode stage registers
   logic               st_ramrd_ff, st_ramrd_in;
   logic [7:0]         st_rd_ff, st_rd_in;
   logic [2:0]         st_tgt_ff, st_tgt_in;
   logic [15:0]        st_da_ff, st_da_in;
   logic [7:0]         st_dd_ff, st_dd_in;

   // Output register
   logic               out_valid_ff;
   logic [7:0]         out_rd_ff;
   logic [2:0]         out_tgt_ff;
   logic [15:0]        out_da_ff;
   logic [7:0]         out_dd_ff;

   logic               accept;
   logic               pend_done;
   logic               in_ready;
   logic               ram_wr_en;
   logic [RAM_AW-1:0]  ram_wr_addr;
   logic [7:0]         ram_wr_data;
   logic               ram_rd_en;
   logic [7:0]         ram_rd_data;
   logic               acc_ram_wr;

   logic               is_write;
   logic               hit_ram, hit_video, hit_audio, hit_dma, hit_pad;
   logic [15:0]        addr;

   // Work RAM
   ccbd_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_work_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_ch.address[RAM_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Handshake
   assign pend_done = pend_ff && (!out_valid_ff || rsp_ch.ready);
   assign accept    = req_ch.valid && in_ready;
   assign req_ch.ready = in_ready;

   // Address decode
   assign addr      = req_ch.address;
   assign is_write  = (req_ch.command == CMD_WRITE);
   assign hit_ram   = (addr & MIRROR_MASK) == RAM_BASE;
   assign hit_video = (addr & MIRROR_MASK) == VIDEO_BASE;
   assign hit_audio = ((addr & PAGE_MASK) == IO_PAGE)
                      && (addr <= AUDIO_LAST || addr == AUDIO_STATUS
                          || addr == AUDIO_FRAME);
   assign hit_dma   = addr == DMA_ADDR;
   assign hit_pad   = addr == PAD_ADDR;
   assign acc_ram_wr = accept && is_write && !req_ch.cart_hit && hit_ram;

   // Next state
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == RAM_AW'(RAM_DEPTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            clr_in = clr_ff;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State outputs: RAM write port and input ready
   always_comb begin
      in_ready    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_ff;
      ram_wr_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         ST_RUN: begin
            in_ready    = !pend_ff || pend_done;
            ram_wr_en   = acc_ram_wr;
            ram_wr_addr = addr[RAM_AW-1:0];
            ram_wr_data = req_ch.write_data;
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   assign ram_rd_en = accept;

   // Decode one access into the stage registers and controller state
   always_comb begin
      st_ramrd_in   = 1'b0;
      st_rd_in      = '0;
      st_tgt_in     = TGT_NONE;
      st_da_in      = '0;
      st_dd_in      = '0;
      pad_strobe_in = pad_strobe_ff;
      pad_shift_in  = pad_shift_ff;
      if (req_ch.cart_hit) begin
         st_tgt_in = TGT_CART;
         st_da_in  = addr;
         if (is_write) begin
            st_dd_in = req_ch.write_data;
         end else begin
            st_rd_in = req_ch.cart_read_data;
         end
      end else if (hit_ram) begin
         st_tgt_in   = TGT_RAM;
         st_ramrd_in = !is_write;
      end else if (hit_video) begin
         st_tgt_in = TGT_VIDEO;
         st_da_in  = addr & VIDEO_REG_MSK;
         if (is_write) begin
            st_dd_in = req_ch.write_data;
         end else begin
            st_rd_in = req_ch.video_read_data;
         end
      end else if (is_write) begin
         if (hit_audio) begin
            st_tgt_in = TGT_AUDIO;
            st_da_in  = addr;
            st_dd_in  = req_ch.write_data;
         end else if (hit_dma) begin
            st_tgt_in = TGT_DMA;
            st_dd_in  = req_ch.write_data;
         end else if (hit_pad) begin
            st_tgt_in     = TGT_PAD;
            pad_strobe_in = req_ch.write_data[0];
            if (req_ch.write_data[0]) begin
               pad_shift_in = req_ch.buttons;
            end
         end
      end else if (hit_pad) begin
         st_tgt_in = TGT_PAD;
         st_rd_in  = PAD_OPEN_BUS | {7'd0, pad_shift_ff[0]};
         if (!pad_strobe_ff) begin
            pad_shift_in = pad_shift_ff >> 1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         pend_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         pad_strobe_ff <= 1'b0;
         pad_shift_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (accept) begin
            pend_ff       <= 1'b1;
            pad_strobe_ff <= pad_strobe_in;
            pad_shift_ff  <= pad_shift_in;
         end else if (pend_done) begin
            pend_ff <= 1'b0;
         end
         if (pend_done) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: capture decode at transfer, merge RAM data on the way out
   always_ff @(posedge clock) begin
      if (accept) begin
         st_ramrd_ff <= st_ramrd_in;
         st_rd_ff    <= st_rd_in;
         st_tgt_ff   <= st_tgt_in;
         st_da_ff    <= st_da_in;
         st_dd_ff    <= st_dd_in;
      end
      if (pend_done) begin
         out_rd_ff  <= st_ramrd_ff ? ram_rd_data : st_rd_ff;
         out_tgt_ff <= st_tgt_ff;
         out_da_ff  <= st_da_ff;
         out_dd_ff  <= st_dd_ff;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.read_data      = out_rd_ff;
   assign rsp_ch.target         = out_tgt_ff;
   assign rsp_ch.device_address = out_da_ff;
   assign rsp_ch.device_data    = out_dd_ff;

   // A pending access reaches a free output register in the next cycle
   a_pend_lands: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !out_valid_ff |=> out_valid_ff)
      else $error("pending access did not reach the output register");

   // RAM writes only come from the clearing pass or a RAM write transfer
   a_ram_wr_src: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR) || acc_ram_wr)
      else $error("stray work RAM write");

   // No transfer while the work RAM is being cleared
   a_no_acc_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !accept && !pend_ff)
      else $error("transfer during RAM clear");

   // Controller read while strobing leaves the shift register alone
   a_pad_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !is_write && !req_ch.cart_hit && hit_pad && pad_strobe_ff
      |=> $stable(pad_shift_ff))
      else $error("controller shifted while strobing");

endmodule
